// ===== rtl/rank_set_bitmap_top_assert.svh =====
// Assertion macros shared by the rank set bitmap RTL.
`ifndef RANK_SET_BITMAP_TOP_ASSERT_SVH
`define RANK_SET_BITMAP_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define RSB_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RSB_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== rtl/rsb_pkg.sv =====
// Shared types and constants for the rank set bitmap.
`default_nettype none
package rsb_pkg;

  localparam int RANK_W           = 10;
  localparam int VALUE_W          = 11;
  localparam int POP_W            = 7;
  localparam int IN_TDATA_W       = 24;
  localparam int OUT_TDATA_W      = 16;
  localparam int SET_CAPACITY_DEF = 1024;
  localparam int WORD_BITS_DEF    = 32;
  localparam int RANK_SPAN        = 1 << RANK_W;
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_DEL   = 3'd1,
    MODE_TEST  = 3'd2,
    MODE_FIRST = 3'd3,
    MODE_MAX   = 3'd4,
    MODE_COUNT = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               full;
    logic               hit;
    logic [VALUE_W-1:0] first_rank;
    logic [VALUE_W-1:0] last_rank;
    logic [POP_W-1:0]   pop;
  } alu_res_t;

endpackage
`default_nettype wire

// ===== rtl/rsb_mem.sv =====
// Bitmap word store: one write port, one registered read port.
`default_nettype none
module rsb_mem #(
  parameter int DEPTH = 32,
  parameter int WB    = 32,
  parameter int AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [WB-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [WB-1:0] rd_data
);

  logic [WB-1:0] words [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      words[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= words[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rsb_word_alu.sv =====
// Per-word unit: range mask, set/clear, coverage test, bit search and popcount.
`default_nettype none
module rsb_word_alu #(
  parameter int WB = 32
) (
  input  wire rsb_pkg::mode_t               mode,
  input  wire logic [WB-1:0]                word,
  input  wire logic [rsb_pkg::VALUE_W-1:0]  base,
  input  wire logic [rsb_pkg::RANK_W-1:0]   lo,
  input  wire logic [rsb_pkg::RANK_W-1:0]   hi,
  output logic      [WB-1:0]                new_word,
  output rsb_pkg::alu_res_t                 res
);

  localparam int IW = $clog2(WB);

  logic [WB-1:0]                mask;
  logic [WB-1:0]                masked;
  logic [IW-1:0]                low_idx;
  logic [IW-1:0]                high_idx;
  logic [rsb_pkg::VALUE_W-1:0]  lo_x;
  logic [rsb_pkg::VALUE_W-1:0]  hi_x;

  assign lo_x = {1'b0, lo};
  assign hi_x = {1'b0, hi};

  // Bit i of this word stands for rank base + i.
  always_comb begin
    for (int i = 0; i < WB; i++) begin
      unique case (mode)
        rsb_pkg::MODE_ADD, rsb_pkg::MODE_DEL, rsb_pkg::MODE_TEST:
          mask[i] = (base + rsb_pkg::VALUE_W'(i) >= lo_x) &&
                    (base + rsb_pkg::VALUE_W'(i) <= hi_x);
        rsb_pkg::MODE_FIRST:
          mask[i] = (base + rsb_pkg::VALUE_W'(i) >= lo_x);
        default:
          mask[i] = 1'b1;
      endcase
    end
  end

  assign masked = word & mask;

  always_comb begin
    unique case (mode)
      rsb_pkg::MODE_ADD: new_word = word | mask;
      rsb_pkg::MODE_DEL: new_word = word & ~mask;
      default:           new_word = word;
    endcase
  end

  // Lowest and highest set bit of the masked word.
  always_comb begin
    low_idx  = '0;
    high_idx = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (masked[i]) begin
        low_idx = IW'(i);
      end
    end
    for (int i = 0; i < WB; i++) begin
      if (masked[i]) begin
        high_idx = IW'(i);
      end
    end
  end

  assign res.full       = (masked == mask);
  assign res.hit        = |masked;
  assign res.first_rank = base + rsb_pkg::VALUE_W'(low_idx);
  assign res.last_rank  = base + rsb_pkg::VALUE_W'(high_idx);
  assign res.pop        = rsb_pkg::POP_W'($countones(word));

endmodule
`default_nettype wire

// ===== rtl/rank_set_bitmap_top.sv =====
// Rank set bitmap: word-serial sequencer around a shared per-word unit.
//
// Membership bitmap of ranks with add, delete and test of a range, search for
// the first member at or after a rank, search for the largest member, and a
// member count. A walking request reads the stored words one per cycle through
// a single word unit, with no stall during the walk; unused modes and adds or
// tests reaching past capacity skip the walk and answer directly. The store
// read port (one word a cycle) sets the walk rate. Only ranks below
// min(SET_CAPACITY, 1024) are stored. After reset a clearing pass zeroes the
// store before the first request is taken. A finished result sits in an
// output register, and the next request may enter while it waits.
`default_nettype none
`include "rank_set_bitmap_top_assert.svh"
module rank_set_bitmap_top #(
  parameter int SET_CAPACITY = rsb_pkg::SET_CAPACITY_DEF,
  parameter int WORD_BITS    = rsb_pkg::WORD_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // [2:0] mode, [12:3] range_a, [22:13] range_b, [23] zero
  input  wire logic [rsb_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [0] flag, [11:1] value, [15:12] zero
  output logic      [rsb_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int RANK_LIMIT = (SET_CAPACITY < rsb_pkg::RANK_SPAN) ?
                              SET_CAPACITY : rsb_pkg::RANK_SPAN;
  localparam int LIVE_WORDS = (RANK_LIMIT + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (LIVE_WORDS > 1) ? $clog2(LIVE_WORDS) : 1;
  localparam int VW         = rsb_pkg::VALUE_W;
  localparam int RW         = rsb_pkg::RANK_W;
  localparam logic [AW-1:0] LAST_IDX  = AW'(LIVE_WORDS - 1);
  localparam logic [VW-1:0] LAST_BASE = VW'((LIVE_WORDS - 1) * WORD_BITS);
  localparam logic [VW-1:0] STEP      = VW'(WORD_BITS);

  rsb_pkg::state_t  state, state_next;
  rsb_pkg::mode_t   mode_in;
  rsb_pkg::mode_t   mode_r;
  rsb_pkg::alu_res_t alu_res;

  logic [RW-1:0]        a_in, b_in, lo_in, hi_in;
  logic [RW-1:0]        lo_r, hi_r;
  logic                 go_walk;
  logic                 in_acc;
  logic                 out_load;
  logic                 iss_on, d_on, d_last;
  logic [AW-1:0]        iss_idx, d_idx;
  logic [VW-1:0]        iss_base, d_base;
  logic                 res_flag;
  logic [VW-1:0]        res_value;
  logic [VW:0]          count_sum;
  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data, rd_data, new_word;
  logic                 clearing, in_done, walk_wr;

  assign mode_in = rsb_pkg::mode_t'(s_tdata[2:0]);
  assign a_in    = s_tdata[12:3];
  assign b_in    = s_tdata[22:13];
  assign lo_in   = (a_in < b_in) ? a_in : b_in;
  assign hi_in   = (a_in < b_in) ? b_in : a_in;
  assign in_acc  = s_tvalid && s_tready;

  assign clearing = (state == rsb_pkg::ST_CLEAR);
  assign in_done  = (state == rsb_pkg::ST_DONE);
  assign walk_wr  = d_on && (mode_r == rsb_pkg::MODE_ADD || mode_r == rsb_pkg::MODE_DEL);

  // Requests that need no walk: unused modes, adds and tests past capacity.
  always_comb begin
    unique case (mode_in)
      rsb_pkg::MODE_ADD, rsb_pkg::MODE_TEST: go_walk = int'(hi_in) < SET_CAPACITY;
      rsb_pkg::MODE_DEL, rsb_pkg::MODE_FIRST,
      rsb_pkg::MODE_MAX, rsb_pkg::MODE_COUNT: go_walk = 1'b1;
      default:                                go_walk = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsb_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = d_idx;
    wr_data    = new_word;
    rd_en      = 1'b0;
    unique case (state)
      rsb_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = iss_idx;
        wr_data = '0;
        if (iss_idx == LAST_IDX) begin
          state_next = rsb_pkg::ST_IDLE;
        end
      end
      rsb_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = go_walk ? rsb_pkg::ST_RUN : rsb_pkg::ST_DONE;
        end
      end
      rsb_pkg::ST_RUN: begin
        rd_en = iss_on;
        wr_en = walk_wr;
        if (d_on && d_last) begin
          state_next = rsb_pkg::ST_DONE;
        end
      end
      rsb_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = rsb_pkg::ST_IDLE;
        end
      end
      default: state_next = rsb_pkg::ST_IDLE;
    endcase
  end

  // Control: issue pointer (also the clear counter), data-valid and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_on   <= 1'b0;
      d_on     <= 1'b0;
      iss_idx  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      d_on <= iss_on;
      if (state == rsb_pkg::ST_CLEAR) begin
        iss_idx <= iss_idx + 1'b1;
      end
      if (in_acc && go_walk) begin
        iss_on  <= 1'b1;
        iss_idx <= (mode_in == rsb_pkg::MODE_MAX) ? LAST_IDX : '0;
      end else if (iss_on) begin
        if ((mode_r == rsb_pkg::MODE_MAX) ? (iss_idx == '0) : (iss_idx == LAST_IDX)) begin
          iss_on <= 1'b0;
        end else if (mode_r == rsb_pkg::MODE_MAX) begin
          iss_idx <= iss_idx - 1'b1;
        end else begin
          iss_idx <= iss_idx + 1'b1;
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign count_sum = {1'b0, res_value} + (VW + 1)'(alu_res.pop);

  // Payload: request fields, walk position, running result and output data.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r    <= mode_in;
      lo_r      <= (mode_in == rsb_pkg::MODE_FIRST) ? a_in : lo_in;
      hi_r      <= hi_in;
      iss_base  <= (mode_in == rsb_pkg::MODE_MAX) ? LAST_BASE : '0;
      res_flag  <= go_walk && (mode_in != rsb_pkg::MODE_FIRST) &&
                   (mode_in != rsb_pkg::MODE_MAX);
      res_value <= '0;
    end else if (iss_on) begin
      iss_base <= (mode_r == rsb_pkg::MODE_MAX) ? iss_base - STEP : iss_base + STEP;
    end
    if (iss_on) begin
      d_idx  <= iss_idx;
      d_base <= iss_base;
      d_last <= (mode_r == rsb_pkg::MODE_MAX) ? (iss_idx == '0) : (iss_idx == LAST_IDX);
    end
    if (d_on) begin
      unique case (mode_r)
        rsb_pkg::MODE_TEST: res_flag <= res_flag && alu_res.full;
        rsb_pkg::MODE_FIRST: begin
          if (!res_flag && alu_res.hit) begin
            res_flag  <= 1'b1;
            res_value <= alu_res.first_rank;
          end
        end
        rsb_pkg::MODE_MAX: begin
          if (!res_flag && alu_res.hit) begin
            res_flag  <= 1'b1;
            res_value <= alu_res.last_rank;
          end
        end
        rsb_pkg::MODE_COUNT: begin
          res_value <= count_sum[VW] ? rsb_pkg::VALUE_MAX : count_sum[VW-1:0];
        end
        default: ;
      endcase
    end
    if (out_load) begin
      m_tdata <= {(rsb_pkg::OUT_TDATA_W - VW - 1)'(0), res_value, res_flag};
    end
  end

  rsb_mem #(
    .DEPTH (LIVE_WORDS),
    .WB    (WORD_BITS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (iss_idx),
    .rd_data (rd_data)
  );

  rsb_word_alu #(
    .WB (WORD_BITS)
  ) u_alu (
    .mode     (mode_r),
    .word     (rd_data),
    .base     (d_base),
    .lo       (lo_r),
    .hi       (hi_r),
    .new_word (new_word),
    .res      (alu_res)
  );

  `RSB_ASSERT_NOW(a_idle_no_walk, clk, rst, s_tready, !iss_on && !d_on, "walk active while ready")
  `RSB_ASSERT_NEXT(a_busy_after_req, clk, rst, in_acc, !s_tready, "ready right after request")
  `RSB_ASSERT_NEXT(a_last_to_done, clk, rst, d_on && d_last, in_done, "last word did not finish")
  `RSB_ASSERT_NOW(a_write_source, clk, rst, wr_en, clearing || walk_wr, "unexpected store write")

endmodule
`default_nettype wire
